// File: rtl/ita_pkg.sv
// Package for the signed integer to radix text converter.
// Holds widths, character codes and the types shared by the converter modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int DIGIT_BITS     = 4;
   localparam int RADIX_BITS     = 5;
   localparam int CHAR_BITS      = 7;
   localparam int BITS_PER_CYCLE = 4;
   localparam int STEPS_PER_DIGIT = VALUE_BITS / BITS_PER_CYCLE;
   localparam int STEP_BITS      = $clog2(STEPS_PER_DIGIT);
   localparam int IDX_BITS       = $clog2(VALUE_BITS);
   localparam int COUNT_BITS     = IDX_BITS + 1;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 5'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 5'd16;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 7'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F = 7'h46;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_X = 7'h78;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

// File: rtl/ita_ifs.sv
// Channel interfaces of the radix text converter: input, result and register write.
// Depends on ita_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ita_req_if import ita_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface ita_rsp_if import ita_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] character;
   logic                 last;
   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

interface ita_csr_if import ita_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [RADIX_BITS-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ita_front.sv
// Front of the converter: accepts an item, takes its sign and magnitude and holds
// the result for the queue. Depends on ita_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ita_front import ita_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   input  wire fifo_status_type              fifo_status,
   output      logic                         push,
   output      entry_type                    push_entry
);

   logic      out_valid_ff, out_valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;

   assign push       = out_valid_ff && !fifo_status.full;
   assign push_entry = entry_ff;
   assign req_ready  = !out_valid_ff || !fifo_status.full;
   assign accept     = req_valid && req_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      entry_in     = entry_ff;
      if (push) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         out_valid_in       = 1'b1;
         entry_in.negative  = req_value[VALUE_BITS-1];
         // The most negative value negates to itself, which read unsigned is exact.
         entry_in.magnitude = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: rtl/ita_fifo.sv
// Two-entry queue that decouples the front from the back of the converter.
// Depends on ita_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ita_fifo import ita_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output      entry_type  pop_entry,
   output fifo_status_type status
);

   entry_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ita_back.sv
// Back of the converter: divides the magnitude by the radix one digit at a time,
// stores the digits and sends sign, prefix and digits as characters. Depends on ita_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ita_back import ita_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [RADIX_BITS-1:0] radix,
   input  wire fifo_status_type       fifo_status,
   input  wire entry_type             pop_entry,
   output      logic                  pop,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [CHAR_BITS-1:0]  rsp_character,
   output      logic                  rsp_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_ZERO  = 3'd3;
   localparam logic [2:0] ST_X     = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_SEND  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIGIT_BITS-1:0] rd_data_ff;

   logic [DIGIT_BITS-1:0] digit_mem [VALUE_BITS];
   logic                  mem_we;
   logic                  mem_re;

   logic [DIGIT_BITS-1:0] div_rem;
   logic [VALUE_BITS-1:0] div_quot;
   logic [DIGIT_BITS:0]   div_trial;
   logic                  out_free;
   logic                  is_oct;
   logic                  is_hex;
   logic [2:0]            after_sign;
   logic [2:0]            after_div;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] wide;
      wide = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
      if (d < DIGIT_BITS'(10)) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_UPPER_A + wide - CHAR_BITS'(10);
   endfunction

   assign is_oct     = (radix == RADIX_OCT);
   assign is_hex     = (radix == RADIX_HEX);
   assign after_sign = (is_oct || is_hex) ? ST_ZERO : ST_READ;
   assign after_div  = neg_ff ? ST_SIGN : after_sign;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == ST_IDLE) && !fifo_status.empty;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // Restoring division, a few quotient bits per cycle; the quotient shifts in
   // behind the dividend so one register holds both.
   always_comb begin
      div_rem   = rem_ff;
      div_quot  = quot_ff;
      div_trial = '0;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         div_trial = {div_rem, div_quot[VALUE_BITS-1]};
         div_quot  = {div_quot[VALUE_BITS-2:0], (div_trial >= radix)};
         if (div_trial >= radix) begin
            div_rem = DIGIT_BITS'(div_trial - radix);
         end else begin
            div_rem = div_trial[DIGIT_BITS-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               quot_in  = pop_entry.magnitude;
               neg_in   = pop_entry.negative;
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = div_quot;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(STEPS_PER_DIGIT - 1)) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               rem_in   = '0;
               step_in  = '0;
               if (div_quot == '0 || count_in == COUNT_BITS'(VALUE_BITS)) begin
                  idx_in   = count_ff[IDX_BITS-1:0];
                  state_in = after_div;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = after_sign;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO;
               rsp_last_in  = 1'b0;
               state_in     = is_hex ? ST_X : ST_READ;
            end
         end
         ST_X: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_LOWER_X;
               rsp_last_in  = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(rd_data_ff);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         quot_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         quot_ff      <= quot_in;
      end
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[count_ff[IDX_BITS-1:0]] <= div_rem;
      end
      if (mem_re) begin
         rd_data_ff <= digit_mem[idx_ff];
      end
   end

endmodule

`default_nettype wire

// File: rtl/signed_integer_to_radix_ascii_top.sv
// An item passes the front register and the queue before the back takes it. The back
// divides out every digit, then sends the sign, any prefix and the digits, reading each
// digit from its store before sending it. The back converts one item at a time and pops
// the next only after its last character; items wait in the front and the queue meanwhile.
// Reset is synchronous: queue emptied, no result pending, radix back to ten.
// Depends on ita_pkg, the channel interfaces, ita_front, ita_fifo and ita_back.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_ascii_top import ita_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   ita_req_if.sink   req_if,
   ita_rsp_if.source rsp_if,
   ita_csr_if.sink   csr_if
);

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [RADIX_BITS-1:0] radix_eff;
   fifo_status_type       fifo_status;
   logic                  push;
   logic                  pop;
   entry_type             push_entry;
   entry_type             pop_entry;

   assign csr_if.ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (csr_if.valid && csr_if.ready) begin
         radix_in = csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   // Codes below two count as binary and codes above sixteen as hexadecimal.
   assign radix_eff = (radix_ff < RADIX_MIN) ? RADIX_MIN :
                      (radix_ff > RADIX_MAX) ? RADIX_MAX : radix_ff;

   ita_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_value   (req_if.value),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   ita_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (fifo_status)
   );

   ita_back u_back (
      .clock         (clock),
      .reset         (reset),
      .radix         (radix_eff),
      .fifo_status   (fifo_status),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_character (rsp_if.character),
      .rsp_last      (rsp_if.last)
   );

   // Every character sent is a sign, a prefix letter or a digit.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.character >= CHAR_ZERO && rsp_if.character <= CHAR_NINE) ||
                        (rsp_if.character >= CHAR_UPPER_A &&
                         rsp_if.character <= CHAR_UPPER_F) ||
                        rsp_if.character == CHAR_MINUS ||
                        rsp_if.character == CHAR_LOWER_X))
      else $error("illegal character on result channel");

   // A full queue must hold back the input once the front has an item waiting.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (fifo_status.full && u_front.out_valid_ff) |-> !req_if.ready)
      else $error("front accepted an item past a full queue");

   // Nothing is pushed into a full queue unless the back drains it in the same cycle.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && fifo_status.full) |-> pop)
      else $error("queue overflow");

   // Just after reset nothing is offered on the result channel.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result offered straight after reset");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the signed integer to radix text converter.
// A scoreboard class predicts the characters of every accepted item; plain tasks drive it.
// Depends on ita_pkg, the channel interfaces in ita_ifs.sv and signed_integer_to_radix_ascii_top.
`timescale 1ns / 1ps

module testbench;
   import ita_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int PHASE_ITEMS      = 17;
   localparam int PHASE_COUNT      = 14;
   localparam int SETTLE_CYCLES    = 50;

   localparam logic signed [VALUE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MOST_POSITIVE = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef struct packed {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_char_type;

   // Predicts the text of each accepted integer and keeps it until the characters arrive.
   class text_scoreboard;
      logic [RADIX_BITS-1:0] radix;
      text_char_type         expected_chars[$];
      int                    errors;

      function void reset_state();
         radix = RADIX_RESET;
         expected_chars.delete();
         errors = 0;
      endfunction

      function void set_radix(logic [RADIX_BITS-1:0] r);
         radix = r;
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      function void note_value(logic signed [VALUE_BITS-1:0] v);
         logic [VALUE_BITS-1:0] rest;
         logic [VALUE_BITS-1:0] base;
         logic [DIGIT_BITS-1:0] d;
         logic [CHAR_BITS-1:0]  text[$];
         text_char_type         entry;
         int                    k;
         if (radix < RADIX_MIN) base = VALUE_BITS'(RADIX_MIN);
         else if (radix > RADIX_MAX) base = VALUE_BITS'(RADIX_MAX);
         else base = VALUE_BITS'(radix);
         rest = v;
         if (v[VALUE_BITS-1]) rest = ~rest + 1'b1;
         // Digits are found least significant first and pushed to the front; the most negative value
         // becomes its plain unsigned magnitude.
         do begin
            d = DIGIT_BITS'(rest % base);
            if (d < 10) text.push_front(CHAR_ZERO + CHAR_BITS'(d));
            else text.push_front(CHAR_UPPER_A + CHAR_BITS'(d - 10));
            rest = rest / base;
         end while (rest != 0);
         if (base == RADIX_HEX) begin
            text.push_front(CHAR_LOWER_X);
            text.push_front(CHAR_ZERO);
         end
         if (base == RADIX_OCT) text.push_front(CHAR_ZERO);
         if (v[VALUE_BITS-1]) text.push_front(CHAR_MINUS);
         for (k = 0; k < text.size(); k++) begin
            entry.character = text[k];
            entry.last      = (k == text.size() - 1);
            expected_chars.push_back(entry);
         end
      endfunction

      function void check_char(logic [CHAR_BITS-1:0] ch, logic last);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t: character %h last %b arrived with none expected", $time, ch, last);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (want.character !== ch) begin
            $display("%0t: character mismatch, expected %h actual %h", $time,
                     want.character, ch);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: last flag mismatch, expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ita_req_if req_if ();
   ita_rsp_if rsp_if ();
   ita_csr_if csr_if ();

   signed_integer_to_radix_ascii_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   text_scoreboard sb;
   bit             idle_enabled = 1'b1;
   bit             long_hold_due = 1'b0;
   int             cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_char(rsp_if.character, rsp_if.last);
   end

   // Receiver: random stalls, plus one long hold-off that lets the block back up.
   initial begin
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return MOST_NEGATIVE;
               default: return MOST_POSITIVE;
            endcase
         end
         1, 2, 3: return $signed(VALUE_BITS'($urandom_range(0, 2000))) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_value(logic signed [VALUE_BITS-1:0] v);
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_value(v);
   endtask

   task automatic maybe_idle_sender();
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every predicted character has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_radix(logic [RADIX_BITS-1:0] r);
      csr_if.valid <= 1'b1;
      csr_if.data  <= r;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.set_radix(r);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic signed [VALUE_BITS-1:0] directed_values[$];
      logic [RADIX_BITS-1:0]        phase_radix[$];
      int                           p;
      int                           n;

      sb = new;
      sb.reset_state();
      req_if.valid = 1'b0;
      req_if.value = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset radix: zero, both extremes, digit boundaries.
      directed_values = '{0, 1, -1, 9, 10, -10, 99, 100, MOST_POSITIVE, MOST_NEGATIVE,
                          MOST_NEGATIVE + 1, 123456789, -987654321, 32'h55555555,
                          32'hAAAAAAAA, 1000000000};
      foreach (directed_values[i]) begin
         maybe_idle_sender();
         send_value(directed_values[i]);
      end
      drain_results();

      // Radices include values below two and above sixteen, and the register's all-zero
      // and all-one patterns.
      phase_radix = '{RADIX_MIN, RADIX_HEX, RADIX_OCT, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3,
                      5'd7, 5'd12, RADIX_RESET};
      while (phase_radix.size() < PHASE_COUNT)
         phase_radix.push_back(RADIX_BITS'($urandom_range(0, 31)));

      for (p = 0; p < PHASE_COUNT; p++) begin
         write_radix(phase_radix[p]);
         idle_enabled = (p < PHASE_COUNT - 2) && ($urandom_range(0, 4) != 0);
         if (p == 2) begin
            // The sender keeps offering items while the receiver holds off.
            idle_enabled  = 1'b0;
            long_hold_due = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
            maybe_idle_sender();
            send_value(random_value());
         end
         if (p == 2) idle_enabled = 1'b1;
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/ita_pkg.sv
rtl/ita_ifs.sv
rtl/ita_front.sv
rtl/ita_fifo.sv
rtl/ita_back.sv
rtl/signed_integer_to_radix_ascii_top.sv
tb/sv/testbench.sv
